// ===== rtl/core/rtq_pkg.sv =====
// Package for the rotation matrix to quaternion unit.
// Holds field widths and the internal pipeline widths; no dependencies.
package rtq_pkg;

  localparam int unsigned FieldW  = 18;
  localparam int unsigned DiffW   = 19;
  localparam int unsigned RadW    = 21;
  localparam int unsigned SqW     = RadW + 16;
  localparam int unsigned RootW   = (SqW + 1) / 2;
  localparam int unsigned NumW    = DiffW + 15;
  localparam int unsigned QuotW   = NumW;
  localparam int unsigned TDataInW  = 168;
  localparam int unsigned TDataOutW = 72;
  localparam int unsigned SqSideW   = 3 + 3 * DiffW;
  localparam int unsigned DivSideW  = RootW + 4;

  localparam logic signed [FieldW-1:0] QOne = 18'sd65536;

endpackage

// ===== rtl/core/rotation_to_quaternion_unit.sv =====
// Top level of the rotation matrix to quaternion unit (Shepperd's method).
// Depends on rtq_pkg, rtq_sqrt and rtq_div.
//
// Usage: one 3x3 matrix word enters on the s_axis channel, one quaternion
// word leaves on the m_axis channel. Matrix entries are signed Q1.16 in 18
// bits; outputs saturate to +-1.0, and m_axis_tuser flags a degenerate
// radicand, in which case all components are zero.
// Throughput is one word per cycle unless the output stalls. A word passes
// stages 1 to 3, the bit-per-stage square root (19 stages), the bit-per-stage
// divider (34 stages) for the three quotient lanes and the output register.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stalled receiver freezes every stage and s_axis_tready
// falls; nothing is lost or repeated. Reset clears all valid bits; no words
// are in flight afterward.
module rotation_to_quaternion_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 upward, zero pad.
  input  logic [rtq_pkg::TDataInW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // q_scalar, q_x, q_y, q_z from bit 0 upward.
  output logic [rtq_pkg::TDataOutW-1:0]   m_axis_tdata,
  // degenerate.
  output logic                            m_axis_tuser
);
  import rtq_pkg::*;

  logic en;
  logic signed [FieldW-1:0] m [9];
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar g = 0; g < 9; g++) begin : g_unpack
    assign m[g] = s_axis_tdata[g*FieldW +: FieldW];
  end

  // Stage 1: trace, diagonal choice.
  logic                     s1_vld_q;
  logic                     s1_pos_q;
  logic [1:0]               s1_i_q;
  logic signed [FieldW-1:0] s1_m_q [9];

  logic signed [FieldW+1:0] trace;
  logic [1:0]               isel;
  logic signed [FieldW-1:0] mii;

  always_comb begin
    trace = (FieldW+2)'(m[0]) + (FieldW+2)'(m[4]) + (FieldW+2)'(m[8]);
    isel  = 2'd0;
    mii   = m[0];
    if (m[4] > m[0]) begin
      isel = 2'd1;
      mii  = m[4];
    end
    if (m[8] > mii) begin
      isel = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q <= trace > 0;
      s1_i_q   <= isel;
      for (int n = 0; n < 9; n++) begin
        s1_m_q[n] <= m[n];
      end
    end
  end

  // Stage 2: radicand and numerators. Order: 0 scalar, 1 x, 2 y, 3 z.
  logic                     s2_vld_q;
  logic signed [RadW-1:0]   s2_u_q;
  logic [1:0]               s2_i_q;
  logic                     s2_pos_q;
  logic signed [DiffW-1:0]  s2_d_q [3];

  logic signed [RadW-1:0]   u;
  logic signed [DiffW-1:0]  d [3];

  function automatic logic signed [DiffW-1:0] sub2(logic signed [FieldW-1:0] a,
                                                   logic signed [FieldW-1:0] b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  function automatic logic signed [DiffW-1:0] add2(logic signed [FieldW-1:0] a,
                                                   logic signed [FieldW-1:0] b);
    return DiffW'(a) + DiffW'(b);
  endfunction

  always_comb begin
    u = RadW'(65536);
    d[0] = '0;
    d[1] = '0;
    d[2] = '0;
    if (s1_pos_q) begin
      u = RadW'(65536) + RadW'(s1_m_q[0]) + RadW'(s1_m_q[4]) + RadW'(s1_m_q[8]);
      d[0] = sub2(s1_m_q[5], s1_m_q[7]);
      d[1] = sub2(s1_m_q[6], s1_m_q[2]);
      d[2] = sub2(s1_m_q[1], s1_m_q[3]);
    end else begin
      case (s1_i_q)
        2'd0: begin
          u = RadW'(65536) + RadW'(s1_m_q[0]) - RadW'(s1_m_q[4]) - RadW'(s1_m_q[8]);
          d[0] = sub2(s1_m_q[5], s1_m_q[7]);
          d[1] = add2(s1_m_q[3], s1_m_q[1]);
          d[2] = add2(s1_m_q[6], s1_m_q[2]);
        end
        2'd1: begin
          u = RadW'(65536) + RadW'(s1_m_q[4]) - RadW'(s1_m_q[8]) - RadW'(s1_m_q[0]);
          d[0] = sub2(s1_m_q[6], s1_m_q[2]);
          d[1] = add2(s1_m_q[7], s1_m_q[5]);
          d[2] = add2(s1_m_q[1], s1_m_q[3]);
        end
        default: begin
          u = RadW'(65536) + RadW'(s1_m_q[8]) - RadW'(s1_m_q[0]) - RadW'(s1_m_q[4]);
          d[0] = sub2(s1_m_q[1], s1_m_q[3]);
          d[1] = add2(s1_m_q[2], s1_m_q[6]);
          d[2] = add2(s1_m_q[5], s1_m_q[7]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_u_q   <= u;
      s2_i_q   <= s1_i_q;
      s2_pos_q <= s1_pos_q;
      for (int n = 0; n < 3; n++) begin
        s2_d_q[n] <= d[n];
      end
    end
  end

  // Stage 3: clamp radicand.
  logic               s3_vld_q;
  logic [SqW-1:0]     s3_rad_q;
  logic [SqSideW-1:0] s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q  <= (s2_u_q > 0) ? {s2_u_q[RadW-2:0], 16'd0, 1'b0} >> 1 : '0;
      s3_side_q <= {s2_pos_q, s2_i_q, s2_d_q[2], s2_d_q[1], s2_d_q[0]};
    end
  end

  logic               sq_vld;
  logic [RootW-1:0]   root;
  logic [SqSideW-1:0] sq_side;

  rtq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // Three dividers share the same root; magnitudes in, signs on the side.
  logic signed [DiffW-1:0] sd [3];
  logic [DiffW-1:0]        mag [3];
  logic [RootW-1:0]        den;
  logic                    dv_vld [3];
  logic [QuotW-1:0]        quot [3];
  logic [DivSideW-1:0]     dside [3];

  always_comb begin
    sd[0] = sq_side[DiffW-1:0];
    sd[1] = sq_side[2*DiffW-1:DiffW];
    sd[2] = sq_side[3*DiffW-1:2*DiffW];
    for (int n = 0; n < 3; n++) begin
      mag[n] = sd[n][DiffW-1] ? DiffW'(-sd[n]) : DiffW'(sd[n]);
    end
    den = (root == '0) ? RootW'(1) : root;
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    logic [NumW-1:0] num;
    // Rounded: (mag * 2^16 + den) / (2 den) equals (mag*2^15 + den/2)/den.
    assign num = {mag[g], 15'd0} + NumW'(den >> 1);
    rtq_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld),
      .num_i   (num),
      .den_i   (den),
      .side_i  ({root, sq_side[SqSideW-1 -: 3], sd[g][DiffW-1]}),
      .valid_o (dv_vld[g]),
      .quot_o  (quot[g]),
      .side_o  (dside[g])
    );
  end

  // Output register: placement, sign, saturation.
  logic [FieldW-1:0] q_q [4];
  logic              deg_q;
  logic [RootW-1:0]  r_o;
  logic              pos_o;
  logic [1:0]        i_o;
  logic signed [FieldW-1:0] dq [3];
  logic signed [FieldW-1:0] half;
  logic signed [FieldW-1:0] qn [4];

  function automatic logic signed [FieldW-1:0] sat(logic [QuotW-1:0] q, logic neg);
    logic [FieldW-1:0] lim;
    lim = (q > QuotW'(65536)) ? QOne : FieldW'(q);
    return neg ? -lim : lim;
  endfunction

  always_comb begin
    r_o   = dside[0][DivSideW-1 -: RootW];
    pos_o = dside[0][3];
    i_o   = dside[0][2:1];
    for (int n = 0; n < 3; n++) begin
      dq[n] = sat(quot[n], dside[n][0]);
    end
    half = FieldW'((RootW+1)'(r_o) + 1 >> 1);
    half = (half > QOne) ? QOne : half;
    qn[0] = dq[0];
    qn[1] = dq[1];
    qn[2] = dq[2];
    qn[3] = '0;
    if (pos_o) begin
      qn[0] = half;
      qn[1] = dq[0];
      qn[2] = dq[1];
      qn[3] = dq[2];
    end else begin
      case (i_o)
        2'd0: begin
          qn[1] = half; qn[2] = dq[1]; qn[3] = dq[2];
        end
        2'd1: begin
          qn[2] = half; qn[3] = dq[1]; qn[1] = dq[2];
        end
        default: begin
          qn[3] = half; qn[1] = dq[1]; qn[2] = dq[2];
        end
      endcase
      if (r_o == '0) begin
        qn[0] = '0; qn[1] = '0; qn[2] = '0; qn[3] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        q_q[n] <= qn[n];
      end
      deg_q <= !pos_o && (r_o == '0);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {q_q[3], q_q[2], q_q[1], q_q[0]};
  assign m_axis_tuser  = deg_q;

`ifndef SYNTHESIS
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !s_axis_tready) else $error("ready while stalled");
  a_div_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld[0] == dv_vld[1]) && (dv_vld[1] == dv_vld[2])) else $error("lanes split");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && deg_q) |-> (m_axis_tdata == '0)) else $error("degenerate not zero");
`endif

endmodule

// ===== rtl/core/rtq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rtq_pkg; carries a sideband word alongside each value.
module rtq_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rtq_pkg::SqW-1:0]     rad_i,
  input  logic [rtq_pkg::SqSideW-1:0] side_i,
  output logic                        valid_o,
  output logic [rtq_pkg::RootW-1:0]   root_o,
  output logic [rtq_pkg::SqSideW-1:0] side_o
);
  import rtq_pkg::*;

  localparam int unsigned RemW = RootW + 2;

  logic [RootW:0]        vld_q;
  logic [SqW+1:0]        x_q    [RootW+1];
  logic [RemW-1:0]       rem_q  [RootW+1];
  logic [RootW-1:0]      res_q  [RootW+1];
  logic [SqSideW-1:0]    side_q [RootW+1];

  always_comb begin
    x_q[0]    = {2'b00, rad_i};
    rem_q[0]  = '0;
    res_q[0]  = '0;
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar g = 0; g < RootW; g++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    always_comb begin
      rem_sh = {rem_q[g][RemW-3:0], x_q[g][SqW -: 2]};
      trial  = {res_q[g], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= x_q[g] << 2;
        side_q[g+1] <= side_q[g];
        if (rem_sh >= trial) begin
          rem_q[g+1] <= rem_sh - trial;
          res_q[g+1] <= {res_q[g][RootW-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= rem_sh;
          res_q[g+1] <= {res_q[g][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = res_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

// ===== rtl/core/rtq_div.sv =====
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per stage.
// Depends on rtq_pkg; carries a sideband word alongside each value.
module rtq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rtq_pkg::NumW-1:0]     num_i,
  input  logic [rtq_pkg::RootW-1:0]    den_i,
  input  logic [rtq_pkg::DivSideW-1:0] side_i,
  output logic                         valid_o,
  output logic [rtq_pkg::QuotW-1:0]    quot_o,
  output logic [rtq_pkg::DivSideW-1:0] side_o
);
  import rtq_pkg::*;

  localparam int unsigned RemW = RootW + 1;

  logic [NumW:0]        vld_q;
  logic [NumW-1:0]      n_q    [NumW+1];
  logic [RemW-1:0]      rem_q  [NumW+1];
  logic [RootW-1:0]     den_q  [NumW+1];
  logic [DivSideW-1:0]  side_q [NumW+1];

  always_comb begin
    n_q[0]    = num_i;
    rem_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [RemW:0] rem_sh;
    always_comb rem_sh = {rem_q[g], n_q[g][NumW-1]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g+1]  <= den_q[g];
        side_q[g+1] <= side_q[g];
        if (rem_sh >= {2'b00, den_q[g]}) begin
          rem_q[g+1] <= RemW'(rem_sh - {2'b00, den_q[g]});
          n_q[g+1]   <= {n_q[g][NumW-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= RemW'(rem_sh);
          n_q[g+1]   <= {n_q[g][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quot_o  = n_q[NumW];
  assign side_o  = side_q[NumW];

endmodule
